>>> hw/rtl/blt_pkg.sv
package blt_pkg;

  localparam int unsigned WordBits    = 16;
  localparam int unsigned MaxRowWords = 64;
  localparam int unsigned MaxRows     = 1024;
  localparam int unsigned ColW        = $clog2(MaxRowWords);
  localparam int unsigned RowW        = $clog2(MaxRows);
  localparam int unsigned ShiftW      = $clog2(WordBits);
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MINTERM    = 3'd0,
    CFG_A_SHIFT    = 3'd1,
    CFG_B_SHIFT    = 3'd2,
    CFG_FIRST_MASK = 3'd3,
    CFG_LAST_MASK  = 3'd4,
    CFG_ROW_WORDS  = 3'd5,
    CFG_ROW_COUNT  = 3'd6,
    CFG_DESCENDING = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  minterm;
    logic [3:0]  a_shift;
    logic [3:0]  b_shift;
    logic [15:0] first_word_mask;
    logic [15:0] last_word_mask;
    logic [6:0]  row_words;
    logic [10:0] row_count;
    logic        descending;
  } cfg_t;

endpackage

>>> hw/rtl/blt_cfg_regs.sv
module blt_cfg_regs
  import blt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MINTERM:    cfg_d.minterm         = cfg_data_i[7:0];
        CFG_A_SHIFT:    cfg_d.a_shift         = cfg_data_i[3:0];
        CFG_B_SHIFT:    cfg_d.b_shift         = cfg_data_i[3:0];
        CFG_FIRST_MASK: cfg_d.first_word_mask = cfg_data_i[15:0];
        CFG_LAST_MASK:  cfg_d.last_word_mask  = cfg_data_i[15:0];
        CFG_ROW_WORDS:  cfg_d.row_words       = cfg_data_i[6:0];
        CFG_ROW_COUNT:  cfg_d.row_count       = cfg_data_i[10:0];
        CFG_DESCENDING: cfg_d.descending      = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.minterm         <= 8'h00;
      cfg_q.a_shift         <= 4'h0;
      cfg_q.b_shift         <= 4'h0;
      cfg_q.first_word_mask <= 16'hFFFF;
      cfg_q.last_word_mask  <= 16'hFFFF;
      cfg_q.row_words       <= 7'd1;
      cfg_q.row_count       <= 11'd1;
      cfg_q.descending      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/blt_shift.sv
module blt_barrel
  import blt_pkg::*;
(
  input  logic [WordBits-1:0] word_i,
  input  logic [ShiftW-1:0]   amount_i,
  input  logic                descending_i,
  input  logic [WordBits-1:0] carry_in_i,
  output logic [WordBits-1:0] word_o,
  output logic [WordBits-1:0] carry_out_o
);

  logic [2*WordBits-1:0] left_w;
  logic [2*WordBits-1:0] right_w;

  // left: {carry, result}; right: {result, carry}
  assign left_w  = {{WordBits{1'b0}}, word_i} << amount_i;
  assign right_w = {word_i, {WordBits{1'b0}}} >> amount_i;

  always_comb begin
    if (amount_i == '0) begin
      // no shift: word passes unchanged and the carry is dropped
      word_o      = word_i;
      carry_out_o = '0;
    end else if (descending_i) begin
      word_o      = left_w[WordBits-1:0] | carry_in_i;
      carry_out_o = left_w[2*WordBits-1:WordBits];
    end else begin
      word_o      = right_w[2*WordBits-1:WordBits] | carry_in_i;
      carry_out_o = right_w[WordBits-1:0];
    end
  end

endmodule

>>> hw/rtl/blt_minterm.sv
module blt_minterm
  import blt_pkg::*;
(
  input  logic [7:0]          minterm_i,
  input  logic [WordBits-1:0] a_i,
  input  logic [WordBits-1:0] b_i,
  input  logic [WordBits-1:0] c_i,
  output logic [WordBits-1:0] d_o
);

  always_comb begin
    for (int unsigned i = 0; i < WordBits; i++) begin
      d_o[i] = minterm_i[{a_i[i], b_i[i], c_i[i]}];
    end
  end

endmodule

>>> hw/rtl/blitter_word_datapath_core.sv
// Channel   Handshake                      Payload
// cfg       cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
// in        in_valid_i / in_ready_o        a_word_i, b_word_i, c_word_i, first_of_blit_i
// out       out_valid_o / out_ready_i      d_word_o, row_end_o, blit_done_o, all_zero_o
//
// One item per cycle unless stalled: input register, mask/shift/minterm logic, result register.
// out_valid_o rises once an accepted item has moved from the input register to the result register.
// cfg_ready_o is always high; a write takes effect in the next cycle.
// Reset clears both stage valids, counters and carries, sets the zero flag.
// A stalled output holds the result and stops the input stage once it is full.
module blitter_word_datapath_core
  import blt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         a_word_i,
  input  logic [15:0]         b_word_i,
  input  logic [15:0]         c_word_i,
  input  logic                first_of_blit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         d_word_o,
  output logic                row_end_o,
  output logic                blit_done_o,
  output logic                all_zero_o
);

  cfg_t cfg;

  logic                in_valid_q;
  logic [15:0]         a_q, b_q, c_q;
  logic                first_q;

  logic                out_valid_q;
  logic [15:0]         d_q, d_d;
  logic                row_end_q, row_end_d;
  logic                done_q, done_d;
  logic                zero_q;

  logic [ColW-1:0]     column_q, column_d, column_cur;
  logic [RowW-1:0]     row_q, row_d, row_cur;
  logic [WordBits-1:0] a_carry_q, a_carry_d, a_carry_cur;
  logic [WordBits-1:0] b_carry_q, b_carry_d, b_carry_cur;
  logic                zero_flag_q, zero_flag_d, zero_flag_cur;

  logic [ColW-1:0]     width_m1;
  logic [RowW-1:0]     height_m1;
  logic                last_col;
  logic [WordBits-1:0] a_masked, a_shifted, b_shifted, a_carry_new, b_carry_new;
  logic                advance;

  blt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // size zero wraps to the maximum, so minus one is a plain wrap
  assign width_m1  = cfg.row_words[ColW-1:0] - ColW'(1);
  assign height_m1 = cfg.row_count[RowW-1:0] - RowW'(1);

  always_comb begin
    column_cur    = first_q ? '0 : column_q;
    row_cur       = first_q ? '0 : row_q;
    a_carry_cur   = first_q ? '0 : a_carry_q;
    b_carry_cur   = first_q ? '0 : b_carry_q;
    zero_flag_cur = first_q ? 1'b1 : zero_flag_q;
    last_col      = column_cur >= width_m1;
    a_masked      = a_q;
    if (column_cur == '0) begin
      a_masked = a_masked & cfg.first_word_mask;
    end
    if (last_col) begin
      a_masked = a_masked & cfg.last_word_mask;
    end
  end

  blt_barrel u_shift_a (
    .word_i       (a_masked),
    .amount_i     (cfg.a_shift),
    .descending_i (cfg.descending),
    .carry_in_i   (a_carry_cur),
    .word_o       (a_shifted),
    .carry_out_o  (a_carry_new)
  );

  blt_barrel u_shift_b (
    .word_i       (b_q),
    .amount_i     (cfg.b_shift),
    .descending_i (cfg.descending),
    .carry_in_i   (b_carry_cur),
    .word_o       (b_shifted),
    .carry_out_o  (b_carry_new)
  );

  blt_minterm u_minterm (
    .minterm_i (cfg.minterm),
    .a_i       (a_shifted),
    .b_i       (b_shifted),
    .c_i       (c_q),
    .d_o       (d_d)
  );

  always_comb begin
    zero_flag_d = zero_flag_cur && (d_d == '0);
    row_end_d   = last_col;
    done_d      = 1'b0;
    if (last_col) begin
      column_d  = '0;
      a_carry_d = '0;
      b_carry_d = '0;
      if (row_cur >= height_m1) begin
        row_d  = '0;
        done_d = 1'b1;
      end else begin
        row_d = row_cur + RowW'(1);
      end
    end else begin
      column_d  = column_cur + ColW'(1);
      row_d     = row_cur;
      a_carry_d = a_carry_new;
      b_carry_d = b_carry_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      column_q    <= '0;
      row_q       <= '0;
      a_carry_q   <= '0;
      b_carry_q   <= '0;
      zero_flag_q <= 1'b1;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        column_q    <= column_d;
        row_q       <= row_d;
        a_carry_q   <= a_carry_d;
        b_carry_q   <= b_carry_d;
        zero_flag_q <= zero_flag_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q     <= a_word_i;
      b_q     <= b_word_i;
      c_q     <= c_word_i;
      first_q <= first_of_blit_i;
    end
    if (advance) begin
      d_q       <= d_d;
      row_end_q <= row_end_d;
      done_q    <= done_d;
      zero_q    <= zero_flag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign d_word_o    = d_q;
  assign row_end_o   = row_end_q;
  assign blit_done_o = done_q;
  assign all_zero_o  = zero_q;

endmodule

>>> verif/tb_blitter_word_datapath_core.sv
module tb_blitter_word_datapath_core;
  import blt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] d_word;
    logic        row_end;
    logic        blit_done;
    logic        all_zero;
  } dest_t;

  // Predicts D words and row/blit flags from A/B/C source words.
  class blit_model;
    cfg_t        regs;
    logic [5:0]  col;
    logic [9:0]  row_q;
    logic [15:0] a_cry;
    logic [15:0] b_cry;
    bit          zflag;
    dest_t       pending_dwords[$];
    int          errors;
    int          checked;
    int          blits;

    function new();
      regs = '{minterm: 8'h00, a_shift: 4'd0, b_shift: 4'd0,
               first_word_mask: 16'hFFFF, last_word_mask: 16'hFFFF,
               row_words: 7'd1, row_count: 11'd1, descending: 1'b0};
      col = '0;
      row_q = '0;
      a_cry = '0;
      b_cry = '0;
      zflag = 1'b1;
      errors = 0;
      checked = 0;
      blits = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_MINTERM:    regs.minterm = v[7:0];
        CFG_A_SHIFT:    regs.a_shift = v[3:0];
        CFG_B_SHIFT:    regs.b_shift = v[3:0];
        CFG_FIRST_MASK: regs.first_word_mask = v;
        CFG_LAST_MASK:  regs.last_word_mask = v;
        CFG_ROW_WORDS:  regs.row_words = v[6:0];
        CFG_ROW_COUNT:  regs.row_count = v[10:0];
        CFG_DESCENDING: regs.descending = v[0];
        default: ;
      endcase
    endfunction

    function logic [15:0] shift_src(logic [15:0] w, logic [3:0] amt, inout logic [15:0] cry);
      logic [15:0] prev;
      logic [15:0] res;
      prev = cry;
      if (amt == 4'd0) begin
        cry = '0;
        return w;
      end
      if (regs.descending) begin
        cry = w >> (16 - amt);
        res = w << amt;
      end else begin
        cry = w << (16 - amt);
        res = w >> amt;
      end
      return res | prev;
    endfunction

    function void take_source(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic first);
      int unsigned width;
      int unsigned height;
      logic [15:0] am;
      logic [15:0] as_w;
      logic [15:0] bs_w;
      logic [15:0] d;
      bit          last_col;
      bit          done;
      dest_t       e;
      width = regs.row_words[5:0];
      if (width == 0) width = 64;
      height = regs.row_count[9:0];
      if (height == 0) height = 1024;
      if (first) begin
        col = '0;
        row_q = '0;
        a_cry = '0;
        b_cry = '0;
        zflag = 1'b1;
      end
      last_col = (col >= width - 1);
      am = a;
      if (col == 0) am &= regs.first_word_mask;
      if (last_col) am &= regs.last_word_mask;
      as_w = shift_src(am, regs.a_shift, a_cry);
      bs_w = shift_src(b, regs.b_shift, b_cry);
      for (int i = 0; i < 16; i++) begin
        d[i] = regs.minterm[{as_w[i], bs_w[i], c[i]}];
      end
      if (d != 16'h0000) zflag = 1'b0;
      done = 1'b0;
      if (last_col) begin
        col = '0;
        a_cry = '0;
        b_cry = '0;
        if (row_q >= height - 1) begin
          row_q = '0;
          done = 1'b1;
          blits++;
        end else begin
          row_q++;
        end
      end else begin
        col++;
      end
      e = '{d_word: d, row_end: last_col, blit_done: done, all_zero: zflag};
      pending_dwords.push_back(e);
    endfunction

    function void check_dest(logic [15:0] d, logic re, logic bd, logic az);
      dest_t e;
      if (pending_dwords.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, d_word %h", $time, d);
        return;
      end
      e = pending_dwords.pop_front();
      checked++;
      if (d !== e.d_word) begin
        errors++;
        $display("%0t: d_word expected %h actual %h", $time, e.d_word, d);
      end
      if (re !== e.row_end) begin
        errors++;
        $display("%0t: row_end expected %b actual %b", $time, e.row_end, re);
      end
      if (bd !== e.blit_done) begin
        errors++;
        $display("%0t: blit_done expected %b actual %b", $time, e.blit_done, bd);
      end
      if (az !== e.all_zero) begin
        errors++;
        $display("%0t: all_zero expected %b actual %b", $time, e.all_zero, az);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [15:0]         a_word_i;
  logic [15:0]         b_word_i;
  logic [15:0]         c_word_i;
  logic                first_of_blit_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [15:0]         d_word_o;
  logic                row_end_o;
  logic                blit_done_o;
  logic                all_zero_o;

  blit_model sb = new();
  int unsigned max_gap = 13;
  int unsigned max_stall = 13;
  int unsigned n_items = 0;
  int unsigned n_settings = 0;
  int unsigned n_directed;

  blitter_word_datapath_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .a_word_i       (a_word_i),
    .b_word_i       (b_word_i),
    .c_word_i       (c_word_i),
    .first_of_blit_i(first_of_blit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .d_word_o       (d_word_o),
    .row_end_o      (row_end_o),
    .blit_done_o    (blit_done_o),
    .all_zero_o     (all_zero_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_dest(d_word_o, row_end_o, blit_done_o, all_zero_o);
    end
  end

  // result side: random stall per item
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, max_stall);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #5_000_000;
    $display("tb_blitter_word_datapath_core: FAIL");
    $finish;
  end

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic program_all(cfg_t c);
    write_reg(CFG_MINTERM, 16'(c.minterm));
    write_reg(CFG_A_SHIFT, 16'(c.a_shift));
    write_reg(CFG_B_SHIFT, 16'(c.b_shift));
    write_reg(CFG_FIRST_MASK, c.first_word_mask);
    write_reg(CFG_LAST_MASK, c.last_word_mask);
    write_reg(CFG_ROW_WORDS, 16'(c.row_words));
    write_reg(CFG_ROW_COUNT, 16'(c.row_count));
    write_reg(CFG_DESCENDING, 16'(c.descending));
    n_settings++;
  endtask

  task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic first);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    a_word_i        = a;
    b_word_i        = b;
    c_word_i        = c;
    first_of_blit_i = first;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_source(a, b, c, first);
    n_items++;
    @(negedge clk_i);
  endtask

  // hold off new items until every outstanding result is back
  task automatic drain();
    int unsigned cnt;
    in_valid_i = 1'b0;
    cnt = 0;
    while (sb.pending_dwords.size() > 0 && cnt < 20000) begin
      @(negedge clk_i);
      cnt++;
    end
    if (sb.pending_dwords.size() > 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending_dwords.size());
      sb.pending_dwords.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.minterm = 8'($urandom_range(0, 255));
    c.a_shift = ($urandom_range(0, 5) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
    c.b_shift = ($urandom_range(0, 5) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
    c.first_word_mask = rand_word();
    c.last_word_mask = rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c.row_words = 7'($urandom_range(1, 8));
      6:                c.row_words = $urandom_range(0, 1) ? 7'd0 : 7'd64;
      7:                c.row_words = 7'($urandom_range(65, 127));
      default:          c.row_words = 7'($urandom_range(0, 127));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c.row_count = 11'($urandom_range(1, 6));
      6:                c.row_count = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1025, 1030));
      default:          c.row_count = 11'($urandom_range(0, 2047));
    endcase
    c.descending = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // one blit from its first word; now and then a broken or noisy one
  task automatic run_blit();
    int unsigned w;
    int unsigned h;
    int unsigned len;
    bit          noisy;
    w = sb.regs.row_words[5:0];
    if (w == 0) w = 64;
    h = sb.regs.row_count[9:0];
    if (h == 0) h = 1024;
    len = w * h;
    if (len > 160) len = $urandom_range(1, 160);
    noisy = ($urandom_range(0, 9) == 0);
    if (noisy) len = $urandom_range(1, len + 3);
    for (int k = 0; k < len; k++) begin
      send_word(rand_word(), rand_word(), rand_word(),
                noisy ? ($urandom_range(0, 7) == 0) : (k == 0));
    end
  endtask

  initial begin
    cfg_t c;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_MINTERM;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    a_word_i        = '0;
    b_word_i        = '0;
    c_word_i        = '0;
    first_of_blit_i = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // D = A, masks on both ends, right shift carry across a 3x2 blit
    c = '{minterm: 8'hF0, a_shift: 4'd4, b_shift: 4'd0, first_word_mask: 16'h00FF,
          last_word_mask: 16'hF000, row_words: 7'd3, row_count: 11'd2, descending: 1'b0};
    program_all(c);
    for (int k = 0; k < 6; k++) send_word(16'hFFFF, 16'h0000, 16'h0000, k == 0);
    drain();

    // D = B, descending with the largest shift
    c = '{minterm: 8'hCC, a_shift: 4'd0, b_shift: 4'd15, first_word_mask: 16'hFFFF,
          last_word_mask: 16'hFFFF, row_words: 7'd2, row_count: 11'd2, descending: 1'b1};
    program_all(c);
    send_word(16'h1234, 16'h8001, 16'h0000, 1'b1);
    send_word(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_word(16'hFFFF, 16'h0001, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h8000, 16'hFFFF, 1'b0);
    drain();

    // D = C at max size, then width and height lowered mid-blit, then run past done
    c = '{minterm: 8'hAA, a_shift: 4'd0, b_shift: 4'd0, first_word_mask: 16'hFFFF,
          last_word_mask: 16'hFFFF, row_words: 7'd0, row_count: 11'd0, descending: 1'b0};
    program_all(c);
    send_word(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
    send_word(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_word(16'h5555, 16'hAAAA, 16'h1234, 1'b0);
    drain();
    write_reg(CFG_ROW_WORDS, 16'd2);
    send_word(16'h0F0F, 16'hF0F0, 16'h00FF, 1'b0);
    drain();
    write_reg(CFG_ROW_WORDS, 16'd1);
    write_reg(CFG_ROW_COUNT, 16'd1);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h0000, 16'h8001, 1'b0);
    drain();

    // constant-zero function with zero masks, then constant-one with wrapped sizes
    c = '{minterm: 8'h00, a_shift: 4'd15, b_shift: 4'd15, first_word_mask: 16'h0000,
          last_word_mask: 16'h0000, row_words: 7'd1, row_count: 11'd1, descending: 1'b1};
    program_all(c);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
    drain();
    c = '{minterm: 8'hFF, a_shift: 4'd0, b_shift: 4'd0, first_word_mask: 16'hFFFF,
          last_word_mask: 16'hFFFF, row_words: 7'd127, row_count: 11'd2047, descending: 1'b0};
    program_all(c);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    drain();
    n_directed = n_items;

    while (n_items < n_directed + 2000) begin
      max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 13;
      max_stall = ($urandom_range(0, 3) == 0) ? 0 : 13;
      program_all(rand_cfg());
      repeat ($urandom_range(1, 4)) run_blit();
      drain();
    end

    max_stall = 0;
    repeat (10) @(negedge clk_i);
    if (sb.pending_dwords.size() > 0) begin
      sb.errors++;
      $display("%0t: %0d results left over", $time, sb.pending_dwords.size());
    end
    $display("Run covered %0d source items and %0d checked results", n_items, sb.checked);
    $display("across %0d register settings, %0d complete blits.", n_settings, sb.blits);
    if (sb.errors == 0) begin
      $display("tb_blitter_word_datapath_core: PASS");
    end else begin
      $display("tb_blitter_word_datapath_core: FAIL");
    end
    $finish;
  end

endmodule
